FILE: hw/rtl/mi3_pkg.sv
// Shared types and widths for the 3x3 fixed-point matrix inverse.
// No dependencies; used by the top level, the divider lane and the checker.
package mi3_pkg;

  // Element width of every matrix entry and of every inverse entry.
  localparam int ELEM_W = 32;
  // Exact 2x2 minor product, signed cofactor and signed determinant widths.
  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = 2 * ELEM_W + 1;
  localparam int DET_W  = 3 * ELEM_W + 3;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t a00;
    elem_t a01;
    elem_t a02;
    elem_t a10;
    elem_t a11;
    elem_t a12;
    elem_t a20;
    elem_t a21;
    elem_t a22;
  } mi3_in_t;

  typedef struct packed {
    elem_t b00;
    elem_t b01;
    elem_t b02;
    elem_t b10;
    elem_t b11;
    elem_t b12;
    elem_t b20;
    elem_t b21;
    elem_t b22;
    logic  singular;
  } mi3_out_t;

  // Control that travels with one quotient through a divider lane.
  typedef struct packed {
    logic neg;   // quotient is negative
    logic big;   // quotient magnitude overflows before rounding
    logic zero;  // determinant is zero
  } lane_ctl_t;

endpackage

FILE: hw/rtl/mi3_div_lane.sv
// Pipelined restoring divider for one inverse element, with rounding and saturation.
// Depends on mi3_pkg for widths and the lane control struct.
module mi3_div_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mi3_pkg::DET_W-1:0]   rem_i,
  input  logic [mi3_pkg::ELEM_W-1:0]  num_i,
  input  logic [mi3_pkg::DET_W-1:0]   den_i,
  input  mi3_pkg::lane_ctl_t          ctl_i,
  output mi3_pkg::elem_t              res_o,
  output logic                        zero_o
);
  import mi3_pkg::*;

  localparam int W  = ELEM_W;
  localparam int QB = ELEM_W;
  localparam int DW = DET_W;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] num_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic [W-1:0]  q_r   [QB+1];
  lane_ctl_t     ctl_r [QB+1];

  logic          rnd;
  logic [W:0]    mag;
  logic [W:0]    lim;
  logic [W:0]    mag_sat;
  elem_t         res_nxt;
  elem_t         res_r;
  logic          zero_r;

  // Stage zero is the lane input.
  assign rem_r[0] = rem_i;
  assign num_r[0] = num_i;
  assign den_r[0] = den_i;
  assign q_r[0]   = '0;
  assign ctl_r[0] = ctl_i;

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int BI = QB - 1 - j;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    assign trial   = {rem_r[j], num_r[j][BI]};
    assign ge      = trial >= {1'b0, den_r[j]};
    assign rem_nxt = ge ? DW'(trial - {1'b0, den_r[j]}) : DW'(trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= rem_nxt;
        num_r[j+1] <= num_r[j];
        den_r[j+1] <= den_r[j];
        q_r[j+1]   <= {q_r[j][W-2:0], ge};
        ctl_r[j+1] <= ctl_r[j];
      end
    end
  end

  // Round half away from zero, saturate, apply sign; zero for a singular matrix.
  always_comb begin
    rnd     = {rem_r[QB], 1'b0} >= {1'b0, den_r[QB]};
    mag     = {1'b0, q_r[QB]} + (W+1)'(rnd);
    lim     = ((W+1)'(1) << (W - 1)) - (W+1)'(!ctl_r[QB].neg);
    mag_sat = (ctl_r[QB].big || (mag > lim)) ? lim : mag;
    if (ctl_r[QB].zero) begin
      res_nxt = '0;
    end else if (ctl_r[QB].neg) begin
      res_nxt = elem_t'(-mag_sat[W-1:0]);
    end else begin
      res_nxt = elem_t'(mag_sat[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      zero_r <= ctl_r[QB].zero;
    end
  end

  assign res_o  = res_r;
  assign zero_o = zero_r;

endmodule

FILE: hw/rtl/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse (adjugate over determinant).
// Depends on mi3_pkg and instantiates nine mi3_div_lane dividers.
//
//  channel | ports                        | moves per transfer
//  --------+------------------------------+-------------------------------
//  input   | in_valid in_ready in_data    | one matrix, nine elements
//  output  | out_valid out_ready out_data | nine inverse elements, singular
//
// One matrix enters per cycle while the pipeline advances, and each one passes
// through the cofactor and determinant stages and then the bit-per-stage dividers.
// All stages advance together whenever the output register is empty or taken,
// so a stall holds every stage in place and nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mi3_pkg::mi3_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mi3_pkg::mi3_out_t out_data
);
  import mi3_pkg::*;

  localparam int W   = ELEM_W;
  localparam int PW  = PROD_W;
  localparam int CW  = COF_W;
  localparam int DW  = DET_W;
  localparam int QB  = ELEM_W;
  localparam int NW  = CW + 2 * FRAC_BITS;
  localparam int LAT = 8 + QB;

  logic adv;
  logic vld_r [LAT];

  elem_t a_in [9];

  logic signed [PW-1:0]    p0_r [9];
  logic signed [PW-1:0]    p1_r [9];
  elem_t                   a0_s1_r [3];
  logic signed [CW-1:0]    cof_s2_r [9];
  elem_t                   a0_s2_r [3];
  logic signed [CW-1:0]    cof_s3_r [9];
  logic signed [PW-1:0]    hi_r [3];
  logic signed [PW+1:0]    lo_r [3];
  logic signed [CW-1:0]    cof_s4_r [9];
  logic signed [DW-1:0]    term_r [3];
  logic signed [CW-1:0]    cof_s5_r [9];
  logic signed [DW-1:0]    det_r;
  logic [CW-1:0]           cmag_r [9];
  logic                    cneg_r [9];
  logic [DW-1:0]           dmag_r;
  logic                    dneg_r;
  logic                    dzero_r;
  logic [DW-1:0]           rem0_r [9];
  logic [QB-1:0]           nlo_r [9];
  logic [DW-1:0]           d7_r;
  lane_ctl_t               ctl7_r [9];
  elem_t                   res [9];
  logic                    zero_l [9];

  // The whole pipeline moves when the output register is free or being taken.
  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;

  assign a_in[0] = in_data.a00;
  assign a_in[1] = in_data.a01;
  assign a_in[2] = in_data.a02;
  assign a_in[3] = in_data.a10;
  assign a_in[4] = in_data.a11;
  assign a_in[5] = in_data.a12;
  assign a_in[6] = in_data.a20;
  assign a_in[7] = in_data.a21;
  assign a_in[8] = in_data.a22;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stages one and two: the two products of each 2x2 minor, then the signed cofactor.
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R1 = (r == 0) ? 1 : 0;
      localparam int R2 = (r == 2) ? 1 : 2;
      localparam int C1 = (c == 0) ? 1 : 0;
      localparam int C2 = (c == 2) ? 1 : 2;
      localparam int K  = r * 3 + c;

      always_ff @(posedge clk) begin
        if (adv) begin
          p0_r[K] <= a_in[R1*3+C1] * a_in[R2*3+C2];
          p1_r[K] <= a_in[R1*3+C2] * a_in[R2*3+C1];
          if (((r + c) % 2) == 1) begin
            cof_s2_r[K] <= CW'(p1_r[K]) - CW'(p0_r[K]);
          end else begin
            cof_s2_r[K] <= CW'(p0_r[K]) - CW'(p1_r[K]);
          end
        end
      end
    end
  end

  // Stages three and four: row-zero terms of the determinant, split into two products.
  for (genvar c = 0; c < 3; c++) begin : g_term
    always_ff @(posedge clk) begin
      if (adv) begin
        a0_s1_r[c] <= a_in[c];
        a0_s2_r[c] <= a0_s1_r[c];
        hi_r[c]    <= a0_s2_r[c] * $signed(cof_s2_r[c][CW-1:W+1]);
        lo_r[c]    <= a0_s2_r[c] * $signed({1'b0, cof_s2_r[c][W:0]});
        term_r[c]  <= (DW'(hi_r[c]) <<< (W + 1)) + DW'(lo_r[c]);
      end
    end
  end

  // Stages three to six: carry the cofactors, sum the determinant, take magnitudes.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        cof_s3_r[k] <= cof_s2_r[k];
        cof_s4_r[k] <= cof_s3_r[k];
        cof_s5_r[k] <= cof_s4_r[k];
        cneg_r[k]   <= cof_s5_r[k][CW-1];
        cmag_r[k]   <= cof_s5_r[k][CW-1] ? CW'(-cof_s5_r[k]) : CW'(cof_s5_r[k]);
      end
      det_r   <= term_r[0] + term_r[1] + term_r[2];
      dneg_r  <= det_r[DW-1];
      dmag_r  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      dzero_r <= (det_r == '0);
    end
  end

  // Stage seven: scale the numerators and set up each divider lane.
  // Inverse element (r,c) divides the cofactor at (c,r).
  for (genvar k = 0; k < 9; k++) begin : g_prep
    localparam int SRC = (k % 3) * 3 + (k / 3);
    logic [NW-1:0]    num;
    logic [NW-QB-1:0] num_hi;

    assign num    = {cmag_r[SRC], {(2*FRAC_BITS){1'b0}}};
    assign num_hi = num[NW-1:QB];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem0_r[k]      <= DW'(num_hi);
        nlo_r[k]       <= num[QB-1:0];
        ctl7_r[k].neg  <= cneg_r[SRC] ^ dneg_r;
        ctl7_r[k].big  <= DW'(num_hi) >= dmag_r;
        ctl7_r[k].zero <= dzero_r;
      end
    end

    mi3_div_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .rem_i  (rem0_r[k]),
      .num_i  (nlo_r[k]),
      .den_i  (d7_r),
      .ctl_i  (ctl7_r[k]),
      .res_o  (res[k]),
      .zero_o (zero_l[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d7_r <= dmag_r;
    end
  end

  // Result transfer straight from the lanes' output registers.
  assign out_valid         = vld_r[LAT-1];
  assign out_data.b00      = res[0];
  assign out_data.b01      = res[1];
  assign out_data.b02      = res[2];
  assign out_data.b10      = res[3];
  assign out_data.b11      = res[4];
  assign out_data.b12      = res[5];
  assign out_data.b20      = res[6];
  assign out_data.b21      = res[7];
  assign out_data.b22      = res[8];
  assign out_data.singular = zero_l[0];

endmodule

FILE: hw/rtl/mi3_chk.sv
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
// Depends on mi3_pkg for the payload types.
module mi3_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input mi3_pkg::mi3_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input mi3_pkg::mi3_out_t out_data
);
  import mi3_pkg::*;

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A singular matrix always reports an all-zero inverse.
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.b00 == '0 && out_data.b01 == '0 && out_data.b02 == '0 &&
      out_data.b10 == '0 && out_data.b11 == '0 && out_data.b12 == '0 &&
      out_data.b20 == '0 && out_data.b21 == '0 && out_data.b22 == '0)
    else $error("singular result with nonzero element");

  // With the output empty, the pipeline takes a new matrix.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A held result stalls the input side.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind matrix_inverse_3x3 mi3_chk u_mi3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/tb_matrix_inverse_3x3.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
// Depends on mi3_pkg and matrix_inverse_3x3; predicts each inverse exactly.
`timescale 1ns / 100ps

module tb_matrix_inverse_3x3;
  import mi3_pkg::*;

  localparam int FRAC      = 16;
  localparam int STALL_MAX = 11;
  localparam int HOLD_LEN  = 300;
  localparam int DOG_LIMIT = 5000;
  localparam int DRAIN     = 8 + ELEM_W + 20;

  typedef logic signed [127:0] wide_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mi3_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mi3_out_t out_data;

  mi3_out_t inv_expected[$];
  int       err_count = 0;
  int       idle_cycles = 0;
  bit       tx_idle = 1'b1;
  bit       rx_idle = 1'b1;
  bit       hold_req = 1'b0;

  matrix_inverse_3x3 #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Rounded, saturated quotient num * 2^(2F) / den.
  function automatic elem_t div_round_sat(wide_t num, wide_t den);
    logic [255:0] n, d, q, r, lim;
    logic         neg;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    n = n << (2 * FRAC);
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    lim = neg ? (256'd1 << (ELEM_W - 1)) : ((256'd1 << (ELEM_W - 1)) - 1);
    if (q > lim) q = lim;
    return neg ? -q[ELEM_W-1:0] : q[ELEM_W-1:0];
  endfunction

  // Inverse as adjugate over the determinant expanded along row 0.
  function automatic mi3_out_t predict_inverse(mi3_in_t m);
    wide_t    a[3][3];
    wide_t    cof[3][3];
    wide_t    det;
    elem_t    b[9];
    mi3_out_t res;
    int       r1, r2, c1, c2;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
    for (int r = 0; r < 3; r++) begin
      r1 = (r == 0) ? 1 : 0;
      r2 = (r == 2) ? 1 : 2;
      for (int c = 0; c < 3; c++) begin
        c1 = (c == 0) ? 1 : 0;
        c2 = (c == 2) ? 1 : 2;
        cof[r][c] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
        if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
      end
    end
    det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
    if (det == 0) begin
      res = '0;
      res.singular = 1'b1;
      return res;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        b[i * 3 + j] = div_round_sat(cof[j][i], det);
    res = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8], 1'b0};
    return res;
  endfunction

  // Sends one matrix and records its expected inverse at the transfer.
  task automatic send_matrix(mi3_in_t m);
    int  gap;
    bit  rdy;
    gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    inv_expected.push_back(predict_inverse(m));
  endtask

  function automatic mi3_in_t make_matrix(elem_t e[9]);
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  function automatic elem_t rand_small(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random matrix: some well conditioned, plus moderate, raw, singular, tiny and edge cases.
  function automatic mi3_in_t rand_matrix();
    elem_t e[9];
    int    kind;
    elem_t edges[6];
    edges = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 32'sh0001_0000};
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        6:       e[k] = $urandom;
        8:       e[k] = rand_small(255);
        9:       e[k] = edges[$urandom_range(0, 5)];
        default: e[k] = rand_small(4 << FRAC);
      endcase
    end
    if (kind < 3) begin
      e[0] = e[0] + (8 << FRAC);
      e[4] = e[4] - (8 << FRAC);
      e[8] = e[8] + (8 << FRAC);
    end
    if (kind == 7) begin
      case ($urandom_range(0, 2))
        0: begin e[6] = e[0]; e[7] = e[1]; e[8] = e[2]; end
        1: begin e[6] = 2 * e[3]; e[7] = 2 * e[4]; e[8] = 2 * e[5]; end
        default: begin e[1] = 0; e[4] = 0; e[7] = 0; end
      endcase
    end
    return make_matrix(e);
  endfunction

  // Edge values, identity, singular and saturating cases.
  task automatic test_directed();
    elem_t one;
    elem_t mx;
    elem_t mn;
    one = 1 << FRAC;
    mx  = 32'sh7fff_ffff;
    mn  = 32'sh8000_0000;
    send_matrix(make_matrix('{one, 0, 0, 0, one, 0, 0, 0, one}));
    send_matrix(make_matrix('{2 * one, 0, 0, 0, -4 * one, 0, 0, 0, one / 2}));
    send_matrix('0);
    send_matrix({9{mx}});
    send_matrix({9{mn}});
    send_matrix(make_matrix('{mx, 0, 0, 0, mx, 0, 0, 0, mx}));
    send_matrix(make_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mn}));
    send_matrix(make_matrix('{mn, mx, 0, mx, mn, 0, 0, 0, mn}));
    send_matrix(make_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_matrix(make_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_matrix(make_matrix('{one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
                              7 * one, 8 * one, 9 * one}));
    send_matrix(make_matrix('{0, one, 0, one, 0, 0, 0, 0, one}));
    send_matrix(make_matrix('{3 * one, one, 0, one, one, 0, 0, 0, -one}));
    send_matrix(make_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
    send_matrix(make_matrix('{3, 0, 0, 0, 3, 0, 0, 0, 3}));
    send_matrix(make_matrix('{mx, mn, 1, -1, mx, mn, mn, 1, mx}));
  endtask

  // Random matrices in chunks, each chunk with randomly chosen idle or back-to-back traffic.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      send_matrix(rand_matrix());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) send_matrix(rand_matrix());
    tx_idle = 1'b1;
  endtask

  // Result side: random stalls, long hold-off on request, and field checks.
  initial begin : result_side
    int       stall_left;
    int       hold_left;
    bit       took;
    mi3_out_t got;
    mi3_out_t want;
    elem_t    gv;
    elem_t    wv;
    string    names[9];
    names = '{"b00", "b01", "b02", "b10", "b11", "b12", "b20", "b21", "b22"};
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      took = out_valid && out_ready && rst_n;
      got  = out_data;
      @(posedge clk);
      if (took) begin
        if (inv_expected.size() == 0) begin
          $error("result transfer with no matrix outstanding");
          err_count++;
        end else begin
          want = inv_expected.pop_front();
          // Element k sits above the singular bit, b00 highest.
          for (int k = 0; k < 9; k++) begin
            gv = got[ELEM_W * (8 - k) + 1 +: ELEM_W];
            wv = want[ELEM_W * (8 - k) + 1 +: ELEM_W];
            if (gv !== wv) begin
              $error("%s: expected %0d, got %0d", names[k], wv, gv);
              err_count++;
            end
          end
          if (got.singular !== want.singular) begin
            $error("singular: expected %0b, got %0b", want.singular, got.singular);
            err_count++;
          end
        end
        stall_left = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= DOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sequencer
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1350);
    test_backpressure();
    // Drop valid at the edge of the last transfer so it is not taken twice.
    in_valid <= 1'b0;
    while (inv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_div_lane.sv
hw/rtl/matrix_inverse_3x3.sv
hw/rtl/mi3_chk.sv
bench/tb_matrix_inverse_3x3.sv
